FILE: hdl/cbtc_pkg.sv
// ----------------------------------------------------------------------------
// cbtc_pkg
// Shared types and constants of the CAN bit timing calculator.
// ----------------------------------------------------------------------------
package cbtc_pkg;

  localparam int unsigned ClkW    = 27;
  localparam int unsigned MaxErrW = 10;
  localparam int unsigned RateW   = 20;
  localparam int unsigned SpW     = 10;
  localparam int unsigned DivNumW = 37;
  localparam int unsigned DivDenW = 27;
  localparam int unsigned DivCntW = 6;

  localparam logic [ClkW-1:0]    ClkReset    = 27'd8000000;
  localparam logic [MaxErrW-1:0] MaxErrReset = 10'd50;

  // register byte addresses
  localparam logic [2:0] AddrClockHz = 3'd0;
  localparam logic [2:0] AddrMaxErr  = 3'd4;

  // result status codes
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusRateErr = 2'd1;
  localparam logic [1:0] StatusBadSp   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BRP,
    S_RATE,
    S_SP1,
    S_SP2,
    S_ERR,
    S_TQ,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  timing_byte_0;
    logic [7:0]  timing_byte_1;
    logic [6:0]  prescaler;
    logic [3:0]  prop_segment;
    logic [4:0]  phase_segment_one;
    logic [3:0]  phase_segment_two;
    logic [9:0]  real_sample_point;
    logic [15:0] quantum_ns;
    logic [9:0]  rate_error_tenths;
  } result_t;

  typedef struct packed {
    logic                start;
    logic [DivNumW-1:0]  dividend;
    logic [DivDenW-1:0]  divisor;
    logic [DivCntW-1:0]  nbits;
  } div_req_t;

endpackage

FILE: hdl/cbtc_in_if.sv
// ----------------------------------------------------------------------------
// cbtc_in_if
// Request channel: bit rate and sample point.
// ----------------------------------------------------------------------------
interface cbtc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] bit_rate;
  logic [9:0]  sample_point_req;

  modport source (output valid, bit_rate, sample_point_req, input ready);
  modport sink   (input valid, bit_rate, sample_point_req, output ready);
endinterface

FILE: hdl/cbtc_out_if.sv
// ----------------------------------------------------------------------------
// cbtc_out_if
// Result channel: timing bytes and decoded timing values.
// ----------------------------------------------------------------------------
interface cbtc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  timing_byte_0;
  logic [7:0]  timing_byte_1;
  logic [6:0]  prescaler;
  logic [3:0]  prop_segment;
  logic [4:0]  phase_segment_one;
  logic [3:0]  phase_segment_two;
  logic [9:0]  real_sample_point;
  logic [15:0] quantum_ns;
  logic [9:0]  rate_error_tenths;

  modport source (output valid, status, timing_byte_0, timing_byte_1, prescaler,
                  prop_segment, phase_segment_one, phase_segment_two,
                  real_sample_point, quantum_ns, rate_error_tenths, input ready);
  modport sink   (input valid, status, timing_byte_0, timing_byte_1, prescaler,
                  prop_segment, phase_segment_one, phase_segment_two,
                  real_sample_point, quantum_ns, rate_error_tenths, output ready);
endinterface

FILE: hdl/cbtc_divider.sv
// ----------------------------------------------------------------------------
// cbtc_divider
// Shared restoring divider, one quotient bit per cycle, producing nbits quotient bits.
// ----------------------------------------------------------------------------
module cbtc_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cbtc_pkg::div_req_t            req_i,
  output logic                          done_o,
  output logic [cbtc_pkg::DivNumW-1:0]  quotient_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [cbtc_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [cbtc_pkg::DivNumW-1:0] num_q, num_d;
  logic [cbtc_pkg::DivDenW-1:0] rem_q, rem_d;
  logic [cbtc_pkg::DivDenW-1:0] den_q, den_d;
  logic [cbtc_pkg::DivDenW+1:0] trial;
  logic [cbtc_pkg::DivCntW-1:0] pre_shift;

  // align the used dividend bits to the top, then subtract and shift
  always_comb begin
    pre_shift = cbtc_pkg::DivCntW'(cbtc_pkg::DivNumW) - req_i.nbits;
    trial = {1'b0, rem_q, num_q[cbtc_pkg::DivNumW-1]} - {2'b00, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.nbits;
      num_d  = req_i.dividend << pre_shift;
      rem_d  = '0;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial[cbtc_pkg::DivDenW+1]) begin
        rem_d = {rem_q[cbtc_pkg::DivDenW-2:0], num_q[cbtc_pkg::DivNumW-1]};
        num_d = {num_q[cbtc_pkg::DivNumW-2:0], 1'b0};
      end else begin
        rem_d = trial[cbtc_pkg::DivDenW-1:0];
        num_d = {num_q[cbtc_pkg::DivNumW-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == cbtc_pkg::DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // hold operands; no reset needed
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

FILE: hdl/can_bit_timing_calculator.sv
// ----------------------------------------------------------------------------
// can_bit_timing_calculator
// Searches CAN segment totals for the best prescaler and sample point.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake        | carries
//  in_i     | sink      | valid/ready      | bit_rate, sample_point_req
//  out_o    | source    | valid/ready      | status, timing bytes, decoded values
//  apb      | slave     | psel/penable     | clock_hz (0x0), max_error_tenths (0x4)
//
//  One item at a time: in_i.ready is high only while idle.
//  Each search step runs the shared divider one to four times; the search
//  takes up to 46 steps, then the final error, split and quantum divides,
//  and stops early on an exact match.
//  Rejected sample points and a zero bit rate show their result in the
//  cycle after the item is accepted.
//  The result holds on out_o until taken; reset clears to idle.
// ----------------------------------------------------------------------------
module can_bit_timing_calculator (
  input  logic         clk_i,
  input  logic         rst_ni,
  cbtc_in_if.sink      in_i,
  cbtc_out_if.source   out_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cbtc_pkg::state_e   state_q, state_d;
  cbtc_pkg::result_t  res_q, res_d;
  cbtc_pkg::div_req_t div_req;

  logic [26:0] clk_q;
  logic [9:0]  max_err_q;
  logic [19:0] rate_q, rate_d;
  logic [9:0]  sp_q, sp_d;
  logic [5:0]  tseg_q, tseg_d;
  logic [26:0] best_err_q, best_err_d;
  logic [9:0]  spt_err_q, spt_err_d;
  logic [4:0]  best_t_q, best_t_d;
  logic [6:0]  win_brp_q, win_brp_d;
  logic [6:0]  brp_q, brp_d;
  logic [4:0]  q1_q, q1_d;
  logic        found_q, found_d;
  logic        final_q, final_d;
  logic        issued_q, issued_d;

  logic        div_done;
  logic [36:0] quot;

  logic [4:0]  seg_t;
  logic [4:0]  total;
  logic signed [6:0] s2a, s1a, s1f, s2f;
  logic [4:0]  num;
  logic [27:0] brp_w;
  logic signed [27:0] e_s;
  logic [26:0] e_abs;
  logic signed [10:0] e2_s;
  logic [9:0]  e2_abs;
  logic [9:0]  err_sat;
  logic        adv;
  logic [9:0]  sp_in;
  logic [6:0]  t1m1, t2m1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_q     <= cbtc_pkg::ClkReset;
      max_err_q <= cbtc_pkg::MaxErrReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == cbtc_pkg::AddrMaxErr[2]) max_err_q <= pwdata[9:0];
      else                                     clk_q     <= pwdata[26:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == cbtc_pkg::AddrMaxErr[2]) ? {22'd0, max_err_q} :
                                                          {5'd0, clk_q};

  // segment split for the current or the chosen total
  always_comb begin
    seg_t = final_q ? best_t_q : tseg_q[5:1];
    total = 5'd1 + 5'(tseg_q[5:1]);
    s2a = 7'(seg_t) + 7'sd1 - 7'(q1_q);
    if (s2a < 7'sd1) s2a = 7'sd1;
    if (s2a > 7'sd8) s2a = 7'sd8;
    s1a = 7'(seg_t) - s2a;
    s1f = s1a;
    s2f = s2a;
    if (s1a > 7'sd16) begin
      s1f = 7'sd16;
      s2f = 7'(seg_t) - 7'sd16;
    end
    if (s1f < 7'sd1) begin
      s1f = 7'sd1;
      s2f = 7'(seg_t) - 7'sd1;
    end
    num  = 5'(7'(seg_t) + 7'sd1 - s2f);
    t1m1 = s1f - 7'sd1;
    t2m1 = s2f - 7'sd1;
  end

  // operand select for the shared divider
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {10'd0, clk_q};
    div_req.divisor  = '0;
    div_req.nbits    = 6'd27;
    case (state_q)
      cbtc_pkg::S_BRP: div_req.divisor = 27'(total) * 27'(rate_q);
      cbtc_pkg::S_RATE: div_req.divisor = 27'(brp_q) * 27'(total);
      cbtc_pkg::S_SP1: begin
        div_req.dividend = 37'(16'(sp_q) * (16'(seg_t) + 16'd1));
        div_req.divisor  = 27'd1000;
        div_req.nbits    = 6'd15;
      end
      cbtc_pkg::S_SP2: begin
        div_req.dividend = 37'(16'(num) * 16'd1000);
        div_req.divisor  = 27'(seg_t) + 27'd1;
        div_req.nbits    = 6'd15;
      end
      cbtc_pkg::S_ERR: begin
        div_req.dividend = 37'(best_err_q) * 37'd1000;
        div_req.divisor  = 27'(rate_q);
        div_req.nbits    = 6'd37;
      end
      cbtc_pkg::S_TQ: begin
        div_req.dividend = 37'(win_brp_q) * 37'd1000000000;
        div_req.divisor  = clk_q;
        div_req.nbits    = 6'd37;
      end
      default: div_req.nbits = 6'd27;
    endcase
    div_req.start = (state_q != cbtc_pkg::S_IDLE) && (state_q != cbtc_pkg::S_OUT) &&
                    !issued_q && !((state_q == cbtc_pkg::S_TQ) && (clk_q == '0));
  end

  cbtc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // sequencer: next state and datapath updates
  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    rate_d     = rate_q;
    sp_d       = sp_q;
    tseg_d     = tseg_q;
    best_err_d = best_err_q;
    spt_err_d  = spt_err_q;
    best_t_d   = best_t_q;
    win_brp_d  = win_brp_q;
    brp_d      = brp_q;
    q1_d       = q1_q;
    found_d    = found_q;
    final_d    = final_q;
    issued_d   = issued_q;
    adv        = 1'b0;
    sp_in      = in_i.sample_point_req;
    brp_w      = 28'(quot) + 28'(tseg_q[0]);
    e_s        = 28'(rate_q) - 28'(quot);
    e_abs      = e_s[27] ? 27'(-e_s) : 27'(e_s);
    e2_s       = 11'(sp_q) - 11'(quot);
    e2_abs     = e2_s[10] ? 10'(-e2_s) : 10'(e2_s);
    err_sat    = (quot > 37'd1023) ? 10'd1023 : quot[9:0];
    if (div_req.start) issued_d = 1'b1;
    if (div_done)      issued_d = 1'b0;
    case (state_q)
      cbtc_pkg::S_IDLE: begin
        if (in_i.valid) begin
          rate_d     = in_i.bit_rate;
          res_d      = '0;
          best_err_d = '1;
          spt_err_d  = 10'd1000;
          found_d    = 1'b0;
          final_d    = 1'b0;
          tseg_d     = 6'd49;
          if ((sp_in > 10'd0 && sp_in < 10'd100) || sp_in >= 10'd1000) begin
            res_d.status = cbtc_pkg::StatusBadSp;
            state_d      = cbtc_pkg::S_OUT;
          end else begin
            if (sp_in != 10'd0)                 sp_d = sp_in;
            else if (in_i.bit_rate > 20'd800000) sp_d = 10'd750;
            else if (in_i.bit_rate > 20'd500000) sp_d = 10'd800;
            else                                 sp_d = 10'd875;
            if (in_i.bit_rate == 20'd0) begin
              res_d.status            = cbtc_pkg::StatusRateErr;
              res_d.rate_error_tenths = 10'd1023;
              state_d                 = cbtc_pkg::S_OUT;
            end else begin
              state_d = cbtc_pkg::S_BRP;
            end
          end
        end
      end
      cbtc_pkg::S_BRP: begin
        if (div_done) begin
          if (brp_w < 28'd1 || brp_w > 28'd64) adv = 1'b1;
          else begin
            brp_d   = brp_w[6:0];
            state_d = cbtc_pkg::S_RATE;
          end
        end
      end
      cbtc_pkg::S_RATE: begin
        if (div_done) begin
          if (e_abs > best_err_q) adv = 1'b1;
          else begin
            best_err_d = e_abs;
            if (e_abs != '0) begin
              best_t_d  = tseg_q[5:1];
              win_brp_d = brp_q;
              found_d   = 1'b1;
              adv       = 1'b1;
            end else begin
              state_d = cbtc_pkg::S_SP1;
            end
          end
        end
      end
      cbtc_pkg::S_SP1: begin
        if (div_done) begin
          q1_d    = quot[4:0];
          state_d = cbtc_pkg::S_SP2;
        end
      end
      cbtc_pkg::S_SP2: begin
        if (div_done) begin
          if (final_q) begin
            res_d.status            = cbtc_pkg::StatusOk;
            res_d.timing_byte_0     = {2'b00, 6'(win_brp_q - 7'd1)};
            res_d.timing_byte_1     = {1'b0, t2m1[2:0], t1m1[3:0]};
            res_d.prescaler         = win_brp_q;
            res_d.prop_segment      = 4'(s1f >>> 1);
            res_d.phase_segment_one = 5'(s1f - (s1f >>> 1));
            res_d.phase_segment_two = 4'(s2f);
            res_d.real_sample_point = quot[9:0];
            state_d                 = cbtc_pkg::S_TQ;
          end else if (e2_abs > spt_err_q) begin
            adv = 1'b1;
          end else begin
            spt_err_d = e2_abs;
            best_t_d  = tseg_q[5:1];
            win_brp_d = brp_q;
            found_d   = 1'b1;
            if (e2_abs == 10'd0) state_d = cbtc_pkg::S_ERR;
            else                 adv     = 1'b1;
          end
        end
      end
      cbtc_pkg::S_ERR: begin
        if (div_done) begin
          res_d.rate_error_tenths = err_sat;
          if (best_err_q != '0 && err_sat > max_err_q) begin
            res_d.status = cbtc_pkg::StatusRateErr;
            state_d      = cbtc_pkg::S_OUT;
          end else begin
            final_d = 1'b1;
            state_d = cbtc_pkg::S_SP1;
          end
        end
      end
      cbtc_pkg::S_TQ: begin
        if (clk_q == '0) begin
          res_d.quantum_ns = 16'd0;
          state_d          = cbtc_pkg::S_OUT;
        end else if (div_done) begin
          res_d.quantum_ns = (quot > 37'd65535) ? 16'hffff : quot[15:0];
          state_d          = cbtc_pkg::S_OUT;
        end
      end
      cbtc_pkg::S_OUT: begin
        if (out_o.ready) state_d = cbtc_pkg::S_IDLE;
      end
      default: state_d = cbtc_pkg::S_IDLE;
    endcase
    // advance to the next total, or finish the search
    if (adv) begin
      if (tseg_q == 6'd4) begin
        if (found_d) state_d = cbtc_pkg::S_ERR;
        else begin
          res_d.status            = cbtc_pkg::StatusRateErr;
          res_d.rate_error_tenths = 10'd1023;
          state_d                 = cbtc_pkg::S_OUT;
        end
      end else begin
        tseg_d  = tseg_q - 6'd1;
        state_d = cbtc_pkg::S_BRP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cbtc_pkg::S_IDLE;
      issued_q <= 1'b0;
      found_q  <= 1'b0;
      final_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      found_q  <= found_d;
      final_q  <= final_d;
    end
  end

  // hold search data and the result
  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    rate_q     <= rate_d;
    sp_q       <= sp_d;
    tseg_q     <= tseg_d;
    best_err_q <= best_err_d;
    spt_err_q  <= spt_err_d;
    best_t_q   <= best_t_d;
    win_brp_q  <= win_brp_d;
    brp_q      <= brp_d;
    q1_q       <= q1_d;
  end

  assign in_i.ready              = (state_q == cbtc_pkg::S_IDLE);
  assign out_o.valid             = (state_q == cbtc_pkg::S_OUT);
  assign out_o.status            = res_q.status;
  assign out_o.timing_byte_0     = res_q.timing_byte_0;
  assign out_o.timing_byte_1     = res_q.timing_byte_1;
  assign out_o.prescaler         = res_q.prescaler;
  assign out_o.prop_segment      = res_q.prop_segment;
  assign out_o.phase_segment_one = res_q.phase_segment_one;
  assign out_o.phase_segment_two = res_q.phase_segment_two;
  assign out_o.real_sample_point = res_q.real_sample_point;
  assign out_o.quantum_ns        = res_q.quantum_ns;
  assign out_o.rate_error_tenths = res_q.rate_error_tenths;

  // a divide is never restarted while one is pending
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issued_q && !div_done |-> !div_req.start)
    else $error("divider restarted while busy");

  // a good result always carries a legal prescaler
  a_ok_presc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == cbtc_pkg::StatusOk |->
      out_o.prescaler >= 7'd1 && out_o.prescaler <= 7'd64)
    else $error("ok result with illegal prescaler");

  // a bad sample point reports nothing else
  a_badsp_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == cbtc_pkg::StatusBadSp |->
      out_o.prescaler == 7'd0 && out_o.rate_error_tenths == 10'd0)
    else $error("bad sample point result not cleared");

  // an accepted item leaves idle at once
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("still idle after accepting an item");

endmodule

FILE: tb/sv/can_bit_timing_calculator_tb.sv
// ----------------------------------------------------------------------------
// can_bit_timing_calculator_tb
// Drives bit rate requests through the calculator and checks each result
// against a behavioral search model of the segment and prescaler choice,
// across several clock and error-limit settings and handshake idling mixes.
// ----------------------------------------------------------------------------
module can_bit_timing_calculator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  cbtc_in_if  req_if ();
  cbtc_out_if res_if ();

  can_bit_timing_calculator u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // model copy of the registers
  longint  clock_hz_q;
  longint  max_err_q;
  cbtc_pkg::result_t timing_q [$];
  int      n_fail;
  int      src_idle_pct;
  int      snk_idle_pct;
  bit      hold_off;

  // directed rows; known marks an expectation typed by hand
  typedef struct {
    logic [19:0] rate;
    logic [9:0]  sp;
    bit          known;
    cbtc_pkg::result_t want;
  } row_t;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Split total segment for a sample point; return achieved sample point.
  function automatic longint split_for_sp(longint sp, longint tseg,
                                          output longint t1, output longint t2);
    longint s1, s2;
    s2 = tseg + 1 - (sp * (tseg + 1)) / 1000;
    if (s2 < 1) s2 = 1;
    if (s2 > 8) s2 = 8;
    s1 = tseg - s2;
    if (s1 > 16) begin
      s1 = 16;
      s2 = tseg - s1;
    end
    if (s1 < 1) begin
      s1 = 1;
      s2 = tseg - s1;
    end
    t1 = s1;
    t2 = s2;
    return (1000 * (tseg + 1 - s2)) / (tseg + 1);
  endfunction

  // Search prescaler and segments for one request.
  function automatic cbtc_pkg::result_t calc_timing(logic [19:0] rate_in, logic [9:0] sp_in);
    cbtc_pkg::result_t r;
    longint  rate, sp, best_err, sp_err, win_tseg, win_brp;
    longint  total, brp, got, e, s, a, b, t1, t2, err_t, spt, tq;
    bit      found;
    r = '0;
    rate = rate_in;
    sp = sp_in;
    best_err = 64'd1000000000;
    sp_err = 1000;
    win_tseg = 0;
    win_brp = 0;
    found = 0;
    if ((sp > 0 && sp < 100) || sp >= 1000) begin
      r.status = cbtc_pkg::StatusBadSp;
      return r;
    end
    if (sp == 0) begin
      if (rate > 800000) sp = 750;
      else if (rate > 500000) sp = 800;
      else sp = 875;
    end
    if (rate != 0) begin
      for (longint tseg = 49; tseg >= 4; tseg--) begin
        total = 1 + tseg / 2;
        brp = clock_hz_q / (total * rate) + (tseg % 2);
        if (brp < 1 || brp > 64) continue;
        got = clock_hz_q / (brp * total);
        e = rate - got;
        if (e < 0) e = -e;
        if (e > best_err) continue;
        best_err = e;
        if (e == 0) begin
          s = split_for_sp(sp, tseg / 2, a, b);
          e = sp - s;
          if (e < 0) e = -e;
          if (e > sp_err) continue;
          sp_err = e;
        end
        win_tseg = tseg / 2;
        win_brp = brp;
        found = 1;
        if (e == 0) break;
      end
    end
    if (!found) begin
      r.status = cbtc_pkg::StatusRateErr;
      r.rate_error_tenths = 10'd1023;
      return r;
    end
    err_t = (best_err * 1000) / rate;
    if (err_t > 1023) err_t = 1023;
    if (best_err != 0 && err_t > max_err_q) begin
      r.status = cbtc_pkg::StatusRateErr;
      r.rate_error_tenths = err_t[9:0];
      return r;
    end
    spt = split_for_sp(sp, win_tseg, t1, t2);
    tq = (clock_hz_q == 0) ? 0 : (win_brp * 64'd1000000000) / clock_hz_q;
    if (tq > 65535) tq = 65535;
    r.status            = cbtc_pkg::StatusOk;
    r.timing_byte_0     = {2'b00, 6'(win_brp - 1)};
    r.timing_byte_1     = {1'b0, 3'(t2 - 1), 4'(t1 - 1)};
    r.prescaler         = 7'(win_brp);
    r.prop_segment      = 4'(t1 / 2);
    r.phase_segment_one = 5'(t1 - t1 / 2);
    r.phase_segment_two = 4'(t2);
    r.real_sample_point = 10'(spt);
    r.quantum_ns        = 16'(tq);
    r.rate_error_tenths = 10'(err_t);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_fail++;
  endtask

  // Take results at random and compare against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    cbtc_pkg::result_t g, w;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        g = '{res_if.status, res_if.timing_byte_0, res_if.timing_byte_1,
              res_if.prescaler, res_if.prop_segment, res_if.phase_segment_one,
              res_if.phase_segment_two, res_if.real_sample_point,
              res_if.quantum_ns, res_if.rate_error_tenths};
        if (timing_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          w = timing_q.pop_front();
          if (g.status != w.status) report_mismatch("status", g.status, w.status);
          if (g.timing_byte_0 != w.timing_byte_0)
            report_mismatch("timing_byte_0", g.timing_byte_0, w.timing_byte_0);
          if (g.timing_byte_1 != w.timing_byte_1)
            report_mismatch("timing_byte_1", g.timing_byte_1, w.timing_byte_1);
          if (g.prescaler != w.prescaler)
            report_mismatch("prescaler", g.prescaler, w.prescaler);
          if (g.prop_segment != w.prop_segment)
            report_mismatch("prop_segment", g.prop_segment, w.prop_segment);
          if (g.phase_segment_one != w.phase_segment_one)
            report_mismatch("phase_segment_one", g.phase_segment_one, w.phase_segment_one);
          if (g.phase_segment_two != w.phase_segment_two)
            report_mismatch("phase_segment_two", g.phase_segment_two, w.phase_segment_two);
          if (g.real_sample_point != w.real_sample_point)
            report_mismatch("real_sample_point", g.real_sample_point, w.real_sample_point);
          if (g.quantum_ns != w.quantum_ns)
            report_mismatch("quantum_ns", g.quantum_ns, w.quantum_ns);
          if (g.rate_error_tenths != w.rate_error_tenths)
            report_mismatch("rate_error_tenths", g.rate_error_tenths, w.rate_error_tenths);
        end
      end
      res_if.ready <= !hold_off && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Write one register through setup and access cycles, then read it back.
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == cbtc_pkg::AddrClockHz) clock_hz_q = data[cbtc_pkg::ClkW-1:0];
    else max_err_q = data[cbtc_pkg::MaxErrW-1:0];
    @(posedge clk_i);
    want = (addr == cbtc_pkg::AddrClockHz) ? 32'(clock_hz_q) : 32'(max_err_q);
    if (prdata != want) report_mismatch("readback", prdata, want);
  endtask

  // Drain outstanding results, settle, then load both registers.
  task automatic set_config(longint clk_hz, longint max_err);
    while (timing_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    write_reg(cbtc_pkg::AddrClockHz, 32'(clk_hz));
    write_reg(cbtc_pkg::AddrMaxErr, 32'(max_err));
  endtask

  // Offer one item; hold valid until accepted, then idle at random.
  task automatic send_item(logic [19:0] rate, logic [9:0] sp);
    req_if.valid            <= 1'b1;
    req_if.bit_rate         <= rate;
    req_if.sample_point_req <= sp;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    timing_q.push_back(calc_timing(rate, sp));
    if ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  endtask

  function automatic logic [19:0] pick_rate();
    int unsigned k;
    k = $urandom_range(9);
    case (k)
      0: return 20'd1000000;
      1: return 20'd500000;
      2: return 20'd250000;
      3: return 20'd125000;
      4: return 20'd800000;
      5: return 20'd50000;
      6: return 20'($urandom_range(1000, 1000000));
      7: return 20'($urandom_range(1, 2000));
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic [9:0] pick_sp();
    int unsigned k;
    k = $urandom_range(9);
    if (k < 3) return 10'd0;
    if (k < 8) return 10'($urandom_range(100, 999));
    return 10'($urandom);
  endfunction

  // Hold the receiver off for a long stretch while requests keep coming.
  task automatic stall_receiver();
    hold_off = 1'b1;
    repeat (8000) @(posedge clk_i);
    hold_off = 1'b0;
  endtask

  row_t rows [$];
  cbtc_pkg::result_t bad_sp, no_brp;

  initial begin
    n_fail       = 0;
    src_idle_pct = 14;
    snk_idle_pct = 53;
    hold_off     = 1'b0;
    clock_hz_q   = 8000000;
    max_err_q    = 50;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    req_if.valid = 1'b0;
    req_if.bit_rate         = '0;
    req_if.sample_point_req = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    bad_sp = '0;
    bad_sp.status = cbtc_pkg::StatusBadSp;
    no_brp = '0;
    no_brp.status = cbtc_pkg::StatusRateErr;
    no_brp.rate_error_tenths = 10'd1023;

    // extremes, automatic points and rejected points under reset settings
    rows = '{
      '{20'd500000,  10'd0,    1'b0, '0},
      '{20'd1000000, 10'd0,    1'b0, '0},
      '{20'd800001,  10'd0,    1'b0, '0},
      '{20'd800000,  10'd0,    1'b0, '0},
      '{20'd500001,  10'd0,    1'b0, '0},
      '{20'd125000,  10'd875,  1'b0, '0},
      '{20'd250000,  10'd100,  1'b0, '0},
      '{20'd250000,  10'd999,  1'b0, '0},
      '{20'd100000,  10'd1,    1'b1, bad_sp},
      '{20'd100000,  10'd99,   1'b1, bad_sp},
      '{20'd100000,  10'd1000, 1'b1, bad_sp},
      '{20'hFFFFF,   10'h3FF,  1'b1, bad_sp},
      '{20'd0,       10'd800,  1'b1, no_brp},
      '{20'd1,       10'd0,    1'b1, no_brp},
      '{20'hFFFFF,   10'd0,    1'b0, '0},
      '{20'd333333,  10'd700,  1'b0, '0},
      '{20'd47000,   10'd600,  1'b0, '0},
      '{20'd6000,    10'd0,    1'b0, '0}
    };
    foreach (rows[i]) begin
      send_item(rows[i].rate, rows[i].sp);
      if (rows[i].known) timing_q[timing_q.size() - 1] = rows[i].want;
    end
    req_if.valid <= 1'b0;

    // high clock with loose limit, slow clock with strict limit, zero clock
    set_config(100000000, 1000);
    send_item(20'd1000000, 10'd0);
    send_item(20'd1, 10'd500);
    send_item(20'd10000, 10'd0);
    req_if.valid <= 1'b0;
    set_config(1000000, 0);
    send_item(20'd125000, 10'd0);
    send_item(20'd333, 10'd900);
    send_item(20'd7, 10'd0);
    req_if.valid <= 1'b0;
    set_config(0, 1023);
    send_item(20'd500000, 10'd0);
    req_if.valid <= 1'b0;
    set_config(16000000, 50);

    // random phases with three idling mixes
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        src_idle_pct = 53;
        snk_idle_pct = 14;
      end else if (ph == 2) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      for (int n = 0; n < 95; n++) begin
        if (ph == 0 && n == 5) fork
          stall_receiver();
        join_none
        if (n % 32 == 31) begin
          req_if.valid <= 1'b0;
          if ($urandom_range(3) == 0)
            set_config(1000000 + 64'($urandom_range(0, 3)) * 33000000, $urandom_range(1023));
          else
            set_config($urandom_range(1000000, 100000000), $urandom_range(0, 1000));
        end
        send_item(pick_rate(), pick_sp());
      end
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end

    while (timing_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("can_bit_timing_calculator_tb: PASS");
    end else begin
      $display("can_bit_timing_calculator_tb: FAIL");
    end
    $finish;
  end

  // Watchdog well past the slowest legal run.
  initial begin
    #20ms;
    $display("can_bit_timing_calculator_tb: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/cbtc_pkg.sv
hdl/cbtc_in_if.sv
hdl/cbtc_out_if.sv
hdl/cbtc_divider.sv
hdl/can_bit_timing_calculator.sv
tb/sv/can_bit_timing_calculator_tb.sv
